>>> hw/rtl/g2g_pkg.sv
package g2g_pkg;

   // Datapath widths.
   localparam int XW = 28;   // CORDIC vector components, signed
   localparam int AW = 25;   // angles in radians * 2^20, signed
   localparam int DW = 19;   // rounded distance before clamping, unsigned Q9.10
   localparam int HW = 17;   // heading error, Q4.12, signed
   localparam int PW = 57;   // distance times inverse CORDIC gain

   // Angle constants, radians * 2^20.
   localparam logic signed [AW-1:0] ANG_PI      = 25'sd3294199;
   localparam logic signed [AW-1:0] ANG_HALF_PI = 25'sd1647099;
   localparam logic signed [AW-1:0] ANG_TWO_PI  = 25'sd6588397;

   // round(2^30 / CORDIC gain).
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   // atan(2^-i) in radians * 2^20.
   localparam int ATAN_TAB [0:23] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0, 0, 0
   };

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_LINEAR_GAIN  = 2'd0,
      REG_ANGULAR_GAIN = 2'd1,
      REG_MAX_DISTANCE = 2'd2,
      REG_DEAD_ZONE    = 2'd3
   } reg_index_type;

endpackage

>>> hw/rtl/go_to_goal_p_controller_top.sv
// Throughput: one item per cycle unless the output stalls; every stage holds
// one item, so a new item may follow in the very next cycle, and a stalled
// output only blocks stages that are full. The rate is set by the
// one-iteration-per-stage CORDIC.
// Reset (synchronous, active high) empties the pipeline and loads the
// default gains, distance clamp and dead zone.
module go_to_goal_p_controller_top import g2g_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // goal_x[15:0], goal_y[31:16], pose_x[47:32], pose_y[63:48],
   // pose_heading[79:64], ref_heading[95:80]
   input  logic [95:0] req_tdata,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // linear_speed[18:0], angular_rate[39:19]
   output logic [39:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Stage numbering: 0 pre-rotation, 1..CORDIC_STAGES CORDIC iterations,
   // then distance scaling, two wrap steps, selection and gain scaling.
   localparam int S_MUL  = CORDIC_STAGES + 1;
   localparam int S_WR1  = CORDIC_STAGES + 2;
   localparam int S_WR2  = CORDIC_STAGES + 3;
   localparam int S_SEL  = CORDIC_STAGES + 4;
   localparam int S_OUT  = CORDIC_STAGES + 5;
   localparam int NSTAGE = CORDIC_STAGES + 6;

   // ------------------------------------------------------------------
   // Configuration registers. The user must write them only while the block is idle; the block has no check for it.
   // ------------------------------------------------------------------
   logic [11:0] linear_gain_ff, angular_gain_ff;
   logic [14:0] max_distance_ff, dead_zone_ff;
   logic        csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff  <= 12'd256;
         angular_gain_ff <= 12'd768;
         max_distance_ff <= 15'd2048;
         dead_zone_ff    <= 15'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LINEAR_GAIN:  linear_gain_ff  <= csr_pwdata[11:0];
            REG_ANGULAR_GAIN: angular_gain_ff <= csr_pwdata[11:0];
            REG_MAX_DISTANCE: max_distance_ff <= csr_pwdata[14:0];
            REG_DEAD_ZONE:    dead_zone_ff    <= csr_pwdata[14:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LINEAR_GAIN:  csr_prdata = {20'd0, linear_gain_ff};
         REG_ANGULAR_GAIN: csr_prdata = {20'd0, angular_gain_ff};
         REG_MAX_DISTANCE: csr_prdata = {17'd0, max_distance_ff};
         REG_DEAD_ZONE:    csr_prdata = {17'd0, dead_zone_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control. Each stage holds one item and moves on when the stage
   // after it is empty or moving itself, so bubbles are squeezed out.
   // ------------------------------------------------------------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] rdy;

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? req_tvalid : vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[S_OUT];

   // ------------------------------------------------------------------
   // Stage 0: position error and pre-rotation into the right half plane.
   // ------------------------------------------------------------------
   logic signed [15:0] goal_x, goal_y, pose_x, pose_y, pose_heading, ref_heading;
   logic signed [16:0] ex, ey;
   logic signed [XW-1:0] ex_w, ey_w;

   assign goal_x       = req_tdata[15:0];
   assign goal_y       = req_tdata[31:16];
   assign pose_x       = req_tdata[47:32];
   assign pose_y       = req_tdata[63:48];
   assign pose_heading = req_tdata[79:64];
   assign ref_heading  = req_tdata[95:80];

   assign ex   = 17'(goal_x) - 17'(pose_x);
   assign ey   = 17'(goal_y) - 17'(pose_y);
   assign ex_w = XW'(ex) <<< 8;
   assign ey_w = XW'(ey) <<< 8;

   logic signed [XW-1:0] x_in [0:CORDIC_STAGES];
   logic signed [XW-1:0] y_in [0:CORDIC_STAGES];
   logic signed [AW-1:0] a_in [0:CORDIC_STAGES];
   logic signed [XW-1:0] x_ff [0:CORDIC_STAGES];
   logic signed [XW-1:0] y_ff [0:CORDIC_STAGES];
   logic signed [AW-1:0] a_ff [0:CORDIC_STAGES];
   logic signed [15:0]   head_ff [0:CORDIC_STAGES];
   logic signed [15:0]   refh_ff [0:CORDIC_STAGES];
   logic                 zero_ff [0:CORDIC_STAGES];

   always_comb begin
      if (ex_w < 0) begin
         if (ey_w >= 0) begin
            x_in[0] = ey_w;
            y_in[0] = -ex_w;
            a_in[0] = ANG_HALF_PI;
         end else begin
            x_in[0] = -ey_w;
            y_in[0] = ex_w;
            a_in[0] = -ANG_HALF_PI;
         end
      end else begin
         x_in[0] = ex_w;
         y_in[0] = ey_w;
         a_in[0] = '0;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC vectoring stages, one iteration each. An arithmetic right shift
   // rounds towards minus infinity, as the iteration requires.
   // ------------------------------------------------------------------
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      localparam logic signed [AW-1:0] ATAN_K = AW'(ATAN_TAB[k]);
      always_comb begin
         if (y_ff[k] < 0) begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            a_in[k+1] = a_ff[k] - ATAN_K;
         end else begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            a_in[k+1] = a_ff[k] + ATAN_K;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CORDIC_STAGES; k++) begin
         if (rdy[k]) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            a_ff[k] <= a_in[k];
            if (k == 0) begin
               head_ff[k] <= pose_heading;
               refh_ff[k] <= ref_heading;
               zero_ff[k] <= (ex == 0) && (ey == 0);
            end else begin
               head_ff[k] <= head_ff[k-1];
               refh_ff[k] <= refh_ff[k-1];
               zero_ff[k] <= zero_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Distance scaling by the inverse CORDIC gain; bearing minus heading.
   // A zero error vector has bearing zero.
   // ------------------------------------------------------------------
   logic [XW-2:0]        mag;
   logic signed [AW-1:0] bear;
   logic [PW-1:0]        prod_ff;
   logic signed [AW-1:0] ang1_ff;
   logic signed [15:0]   head1_ff, refh1_ff;

   assign mag  = x_ff[CORDIC_STAGES][XW-1] ? '0 : x_ff[CORDIC_STAGES][XW-2:0];
   assign bear = zero_ff[CORDIC_STAGES] ? '0 : a_ff[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (rdy[S_MUL]) begin
         prod_ff  <= PW'(mag) * PW'(INV_GAIN_Q30);
         ang1_ff  <= bear - (AW'(head_ff[CORDIC_STAGES]) <<< 8);
         head1_ff <= head_ff[CORDIC_STAGES];
         refh1_ff <= refh_ff[CORDIC_STAGES];
      end
   end

   // ------------------------------------------------------------------
   // Round the distance; first step of wrapping the heading error.
   // ------------------------------------------------------------------
   logic [PW-1:0]        prod_rnd;
   logic [DW-1:0]        dist2_ff;
   logic signed [AW-1:0] ang2_ff;
   logic signed [15:0]   head2_ff, refh2_ff;

   assign prod_rnd = prod_ff + (PW'(1) << 37);

   always_ff @(posedge clock) begin
      if (rdy[S_WR1]) begin
         dist2_ff <= prod_rnd[PW-1:38];
         if (ang1_ff >= ANG_PI) begin
            ang2_ff <= ang1_ff - ANG_TWO_PI;
         end else if (ang1_ff < -ANG_PI) begin
            ang2_ff <= ang1_ff + ANG_TWO_PI;
         end else begin
            ang2_ff <= ang1_ff;
         end
         head2_ff <= head1_ff;
         refh2_ff <= refh1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Second wrap step, then round the heading error to Q4.12.
   // ------------------------------------------------------------------
   logic signed [AW-1:0] ang3;
   logic signed [AW-1:0] ang3_rnd;
   logic [DW-1:0]        dist3_ff;
   logic signed [HW-1:0] herr3_ff;
   logic signed [HW-1:0] align3_ff;

   always_comb begin
      if (ang2_ff >= ANG_PI) begin
         ang3 = ang2_ff - ANG_TWO_PI;
      end else if (ang2_ff < -ANG_PI) begin
         ang3 = ang2_ff + ANG_TWO_PI;
      end else begin
         ang3 = ang2_ff;
      end
      ang3_rnd = ang3 + AW'(128);
   end

   always_ff @(posedge clock) begin
      if (rdy[S_WR2]) begin
         dist3_ff  <= dist2_ff;
         herr3_ff  <= ang3_rnd[AW-1:8];
         align3_ff <= HW'(refh2_ff) - HW'(head2_ff);
      end
   end

   // ------------------------------------------------------------------
   // Clamp far goals; inside the dead zone stop and align to the reference.
   // ------------------------------------------------------------------
   logic [14:0]          dsel_ff;
   logic signed [HW-1:0] hsel_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_SEL]) begin
         priority if (dist3_ff > DW'(max_distance_ff)) begin
            dsel_ff <= max_distance_ff;
            hsel_ff <= herr3_ff;
         end else if (dist3_ff < DW'(dead_zone_ff)) begin
            dsel_ff <= '0;
            hsel_ff <= align3_ff;
         end else begin
            dsel_ff <= dist3_ff[14:0];
            hsel_ff <= herr3_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Gain scaling with round half up; this is the output register.
   // ------------------------------------------------------------------
   logic [26:0]        lin_prod;
   logic signed [29:0] ang_prod;
   logic [DW-1:0]      lin_ff;
   logic [20:0]        rate_ff;

   assign lin_prod = 27'(linear_gain_ff) * 27'(dsel_ff) + 27'd128;
   assign ang_prod = $signed({1'b0, angular_gain_ff}) * 30'(hsel_ff) + 30'sd128;

   always_ff @(posedge clock) begin
      if (rdy[S_OUT]) begin
         lin_ff  <= lin_prod[26:8];
         rate_ff <= ang_prod[28:8];
      end
   end

   assign rsp_tdata = {rate_ff, lin_ff};

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("pipeline holds an item just after reset");

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff))
      else $error("input refused while a stage is empty");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_SEL] |-> (dsel_ff <= max_distance_ff))
      else $error("selected distance beyond the clamp");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_OUT] && !rsp_tready && vld_ff[S_SEL] |=> $stable(dsel_ff))
      else $error("selection stage moved while the output was stalled");

endmodule
